>>> hw/rtl/iso_ts_pkg.sv
// ----------------------------------------------------------------------------
// ISO timestamp scanner package
// Shared types, character codes, window layout and result codes.
// ----------------------------------------------------------------------------
package iso_ts_pkg;

  localparam int WIN_LEN    = 19;
  localparam int NUM_DIGITS = 14;

  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_NINE  = 16'h0039;
  localparam logic [15:0] CH_DASH  = 16'h002D;
  localparam logic [15:0] CH_COLON = 16'h003A;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_T     = 16'h0054;
  localparam logic [15:0] CH_DOT   = 16'h002E;
  localparam logic [15:0] CH_COMMA = 16'h002C;

  localparam logic [13:0] FRAC_LIMIT = 14'd1000;
  localparam logic [9:0]  FRAC_SAT   = 10'd1023;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_VALID   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_AFTER,
    PH_FRAC,
    PH_DONE
  } phase_t;

  // What a window position must hold for the form to match.
  typedef enum logic [1:0] {
    K_DIGIT,
    K_DASH,
    K_COLON,
    K_SEP
  } kind_t;

  localparam kind_t WIN_KIND [WIN_LEN] = '{
    K_DIGIT, K_DIGIT, K_DIGIT, K_DIGIT, K_DASH, K_DIGIT, K_DIGIT, K_DASH,
    K_DIGIT, K_DIGIT, K_SEP, K_DIGIT, K_DIGIT, K_COLON, K_DIGIT, K_DIGIT,
    K_COLON, K_DIGIT, K_DIGIT
  };

  localparam logic [4:0] DIGIT_POS [NUM_DIGITS] = '{
    5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd8, 5'd9, 5'd11, 5'd12, 5'd14, 5'd15,
    5'd17, 5'd18
  };

  // Compressed form of one code unit as the window needs it.
  typedef struct packed {
    logic       is_dig;
    logic [3:0] dig;
    logic       dash;
    logic       colon;
    logic       sep;
  } cls_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_unit;
    logic        end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [13:0] year;
    logic [6:0] month;
    logic [6:0] day;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
    logic [9:0] millis;
  } out_item_t;

  // State of a finished line, handed from the scanner to the evaluator.
  typedef struct packed {
    logic                           found;
    logic                           too_big;
    logic [9:0]                     frac;
    logic [NUM_DIGITS-1:0][3:0]     digits;
  } snap_t;

  function automatic logic is_digit(input logic [15:0] u);
    return (u >= CH_ZERO) && (u <= CH_NINE);
  endfunction

  function automatic cls_t classify(input logic [15:0] u);
    cls_t c;
    c.is_dig = is_digit(u);
    c.dig    = u[3:0];
    c.dash   = (u == CH_DASH);
    c.colon  = (u == CH_COLON);
    c.sep    = (u == CH_SPACE) || (u == CH_T);
    return c;
  endfunction

endpackage

>>> hw/rtl/iso_ts_in_if.sv
// ----------------------------------------------------------------------------
// Code unit channel
// Valid/ready channel that carries one code unit of a log line.
// ----------------------------------------------------------------------------
interface iso_ts_in_if import iso_ts_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/iso_ts_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the scan outcome of one line.
// ----------------------------------------------------------------------------
interface iso_ts_out_if import iso_ts_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/iso_timestamp_scanner.sv
// ----------------------------------------------------------------------------
// ISO timestamp scanner
// Finds the first date-time form of a log line and reports it at line end.
// ----------------------------------------------------------------------------
// Usage:
// Code units of a line enter on the units channel, one per transfer. An item
// with has_unit low adds nothing; the item with end_of_line high closes the
// line and causes exactly one result on the results channel.
// The scanner takes one code unit every cycle while units.ready is high. The
// last 19 units sit in a row of window cells that shift by one position per
// unit; all position checks of the form are parallel compares over the cells.
// Once the form is seen the cells freeze and hold its digits.
// The result of a line passes from the snapshot register through the
// evaluator into the output register. The next line can start as soon as
// the end_of_line item is taken, unless both registers are full.
// When the receiver stalls, the output register and the snapshot register
// hold up to two finished lines; once both are full, every unit is refused
// until the receiver takes a result. Reset clears the window, the scan state
// and the valid bits of both registers; no result is pending after reset.
// ----------------------------------------------------------------------------
module iso_timestamp_scanner import iso_ts_pkg::*; (
  input logic         clk,
  input logic         rst,
  iso_ts_in_if.sink   units,
  iso_ts_out_if.source results
);

  logic     accept;
  logic     consume;
  logic     eol;
  logic     shift;
  logic     match;
  cls_t     new_cls;
  cls_t     win_q   [WIN_LEN];
  cls_t     win_nxt [WIN_LEN];
  cls_t     win_din [WIN_LEN];

  phase_t      phase;
  phase_t      phase_next;
  logic        pend;
  logic        pend_next;
  logic [9:0]  frac;
  logic [9:0]  frac_next;
  logic        big;
  logic        big_next;
  logic [13:0] frac_mac;
  logic        unit_dig;

  logic      snap_valid;
  snap_t     snap;
  snap_t     snap_new;
  logic      snap_move;
  logic      out_valid;
  out_item_t out_data;
  out_item_t eval_result;

  assign snap_move   = snap_valid && (!out_valid || results.ready);
  assign units.ready = !snap_valid || snap_move;
  assign accept      = units.valid && units.ready;
  assign consume     = accept && units.data.has_unit;
  assign eol         = accept && units.data.end_of_line;
  assign shift       = consume && (phase == PH_SEARCH);
  assign new_cls     = classify(units.data.code_unit);
  assign unit_dig    = is_digit(units.data.code_unit);

  for (genvar i = 0; i < WIN_LEN; i++) begin : g_win
    if (i == WIN_LEN - 1) begin : g_tail
      assign win_din[i] = new_cls;
    end else begin : g_body
      assign win_din[i] = win_q[i+1];
    end
    iso_ts_cell u_cell (
      .clk (clk),
      .rst (rst),
      .clr (eol),
      .en  (shift),
      .din (win_din[i]),
      .q   (win_q[i]),
      .nxt (win_nxt[i])
    );
  end

  // The form test looks at the window as it stands after this unit.
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < WIN_LEN; i++) begin
      case (WIN_KIND[i])
        K_DIGIT: match = match & win_nxt[i].is_dig;
        K_DASH:  match = match & win_nxt[i].dash;
        K_COLON: match = match & win_nxt[i].colon;
        K_SEP:   match = match & win_nxt[i].sep;
        default: match = 1'b0;
      endcase
    end
  end

  assign frac_mac = {4'b0, frac} * 14'd10 + {10'b0, units.data.code_unit[3:0]};

  always_comb begin
    phase_next = phase;
    pend_next  = pend;
    frac_next  = frac;
    big_next   = big;
    case (phase)
      PH_SEARCH: begin
        if (shift && match) begin
          phase_next = PH_AFTER;
          pend_next  = 1'b0;
        end
      end
      PH_AFTER: begin
        if (consume) begin
          if (!pend) begin
            if ((units.data.code_unit == CH_DOT) || (units.data.code_unit == CH_COMMA)) begin
              pend_next = 1'b1;
            end else begin
              phase_next = PH_DONE;
            end
          end else begin
            pend_next = 1'b0;
            if (unit_dig) begin
              frac_next  = {6'b0, units.data.code_unit[3:0]};
              phase_next = PH_FRAC;
            end else begin
              phase_next = PH_DONE;
            end
          end
        end
      end
      PH_FRAC: begin
        if (consume) begin
          if (unit_dig) begin
            if (!big) begin
              if (frac_mac >= FRAC_LIMIT) begin
                big_next  = 1'b1;
                frac_next = FRAC_SAT;
              end else begin
                frac_next = frac_mac[9:0];
              end
            end
          end else begin
            phase_next = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || eol) begin
      phase <= PH_SEARCH;
      pend  <= 1'b0;
      frac  <= '0;
      big   <= 1'b0;
    end else begin
      phase <= phase_next;
      pend  <= pend_next;
      frac  <= frac_next;
      big   <= big_next;
    end
  end

  always_comb begin
    snap_new.found   = (phase_next != PH_SEARCH);
    snap_new.too_big = big_next;
    snap_new.frac    = frac_next;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      snap_new.digits[k] = win_nxt[DIGIT_POS[k]].dig;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (eol) begin
      snap_valid <= 1'b1;
    end else if (snap_move) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eol) begin
      snap <= snap_new;
    end
  end

  iso_ts_eval u_eval (
    .snap   (snap),
    .result (eval_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_move) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_move) begin
      out_data <= eval_result;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

endmodule

>>> hw/rtl/iso_ts_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// One position of the scan window; takes its neighbor's value on a shift.
// ----------------------------------------------------------------------------
module iso_ts_cell import iso_ts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic clr,
  input  logic en,
  input  cls_t din,
  output cls_t q,
  output cls_t nxt
);

  assign nxt = en ? din : q;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      q <= '0;
    end else begin
      q <= nxt;
    end
  end

endmodule

>>> hw/rtl/iso_ts_eval.sv
// ----------------------------------------------------------------------------
// Timestamp evaluator
// Turns the captured digits of a line into field values and a status.
// ----------------------------------------------------------------------------
module iso_ts_eval import iso_ts_pkg::*; (
  input  snap_t     snap,
  output out_item_t result
);

  logic [6:0]  cc;
  logic [6:0]  yy;
  logic [13:0] year;
  logic [6:0]  month;
  logic [6:0]  day;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [6:0]  second;
  logic        leap;
  logic [4:0]  mdays;
  logic        ok;

  function automatic logic [6:0] pair(input logic [3:0] hi, input logic [3:0] lo);
    return {3'b0, hi} * 7'd10 + {3'b0, lo};
  endfunction

  assign cc     = pair(snap.digits[0], snap.digits[1]);
  assign yy     = pair(snap.digits[2], snap.digits[3]);
  assign year   = {7'b0, cc} * 14'd100 + {7'b0, yy};
  assign month  = pair(snap.digits[4], snap.digits[5]);
  assign day    = pair(snap.digits[6], snap.digits[7]);
  assign hour   = pair(snap.digits[8], snap.digits[9]);
  assign minute = pair(snap.digits[10], snap.digits[11]);
  assign second = pair(snap.digits[12], snap.digits[13]);

  // A century year is a leap year only when its first two digits divide by four.
  assign leap = (yy != 7'd0) ? (yy[1:0] == 2'b00) : (cc[1:0] == 2'b00);

  always_comb begin
    case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: mdays = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    mdays = 5'd30;
      7'd2:                                       mdays = leap ? 5'd29 : 5'd28;
      default:                                    mdays = 5'd0;
    endcase
  end

  assign ok = (year != 14'd0) && (day != 7'd0) && (day <= {2'b0, mdays}) &&
              (hour < 7'd24) && (minute < 7'd60) && (second < 7'd60) && !snap.too_big;

  always_comb begin
    result = '0;
    if (snap.found) begin
      result.status = ok ? ST_VALID : ST_INVALID;
      result.year   = year;
      result.month  = month;
      result.day    = day;
      result.hour   = hour;
      result.minute = minute;
      result.second = second;
      result.millis = ok ? snap.frac : 10'd0;
    end
  end

endmodule

>>> hw/rtl/iso_ts_sva.sv
// ----------------------------------------------------------------------------
// ISO timestamp scanner checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module iso_ts_sva import iso_ts_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_ready,
  input out_item_t res_data
);

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.status == ST_NONE) |->
      (res_data.year == 14'd0) && (res_data.month == 7'd0) && (res_data.day == 7'd0) &&
      (res_data.hour == 7'd0) && (res_data.minute == 7'd0) &&
      (res_data.second == 7'd0) && (res_data.millis == 10'd0))
    else $error("line without form reports nonzero fields");

  a_millis_gate: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.status != ST_VALID) |-> (res_data.millis == 10'd0))
    else $error("millis reported for a line that is not valid");

  a_valid_ranges: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.status == ST_VALID) |->
      (res_data.year != 14'd0) && (res_data.month != 7'd0) && (res_data.month <= 7'd12) &&
      (res_data.day != 7'd0) && (res_data.day <= 7'd31) && (res_data.hour < 7'd24) &&
      (res_data.minute < 7'd60) && (res_data.second < 7'd60) &&
      (res_data.millis < 10'd1000))
    else $error("valid timestamp with a field out of range");

endmodule

bind iso_timestamp_scanner iso_ts_sva u_iso_ts_sva (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_data  (results.data)
);

>>> dv/iso_timestamp_scanner_tb.sv
// ----------------------------------------------------------------------------
// ISO timestamp scanner testbench
// Streams log lines through the scanner: a few directed lines, then random
// lines built around date-time forms, broken forms and noise. A line-level
// predictor derives each expected outcome, and a scoreboard compares every
// result with it field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module iso_timestamp_scanner_tb;
  import iso_ts_pkg::*;

  localparam int ITEM_TARGET      = 1550;
  localparam int QUIET_TAIL_ITEMS = 200;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int SETTLE_CYCLES    = 10;

  // Units that sit on the edges of the compares inside the scanner.
  localparam logic [15:0] ODD_UNITS [14] = '{
    CH_DASH, CH_COLON, CH_SPACE, CH_T, CH_DOT, CH_COMMA, 16'h002F, 16'h0074,
    16'h0130, 16'h1030, 16'hFF10, 16'h8039, 16'h0000, 16'hFFFF
  };

  // Predicts the outcome of each line and holds it until the result arrives.
  class timestamp_outcome_board;
    logic [15:0] win [WIN_LEN];
    phase_t      phase;
    logic [3:0]  digs [NUM_DIGITS];
    logic [9:0]  frac;
    bit          frac_over;
    bit          mark_seen;
    int          units_in_win;
    out_item_t   awaited_outcomes [$];
    int          mismatches;

    function new();
      clear_line();
      mismatches = 0;
    endfunction

    function void clear_line();
      foreach (win[k]) win[k] = '0;
      foreach (digs[k]) digs[k] = '0;
      phase        = PH_SEARCH;
      frac         = '0;
      frac_over    = 1'b0;
      mark_seen    = 1'b0;
      units_in_win = 0;
    endfunction

    static function bit is_num(logic [15:0] u);
      return u >= CH_ZERO && u <= CH_NINE;
    endfunction

    static function int days_in_month(int y, int m);
      bit leap;
      leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
      if (m < 1 || m > 12) return 0;
      if (m == 2) return leap ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    function bit form_in_window();
      for (int k = 0; k < WIN_LEN; k++) begin
        case (k)
          4, 7: if (win[k] != CH_DASH) return 1'b0;
          13, 16: if (win[k] != CH_COLON) return 1'b0;
          10: if (win[k] != CH_SPACE && win[k] != CH_T) return 1'b0;
          default: if (!is_num(win[k])) return 1'b0;
        endcase
      end
      return 1'b1;
    endfunction

    function int pair(int k);
      return int'(digs[k]) * 10 + int'(digs[k + 1]);
    endfunction

    function void take_unit(logic [15:0] u);
      int v;
      int j;
      case (phase)
        PH_SEARCH: begin
          for (int k = 0; k < WIN_LEN - 1; k++) win[k] = win[k + 1];
          win[WIN_LEN - 1] = u;
          if (units_in_win < WIN_LEN) units_in_win++;
          if (units_in_win == WIN_LEN && form_in_window()) begin
            j = 0;
            for (int k = 0; k < WIN_LEN; k++) begin
              if (is_num(win[k])) begin
                digs[j] = win[k][3:0];
                j++;
              end
            end
            phase     = PH_AFTER;
            mark_seen = 1'b0;
          end
        end
        PH_AFTER: begin
          if (!mark_seen) begin
            if (u == CH_DOT || u == CH_COMMA) mark_seen = 1'b1;
            else phase = PH_DONE;
          end else begin
            mark_seen = 1'b0;
            if (is_num(u)) begin
              frac  = {6'd0, u[3:0]};
              phase = PH_FRAC;
            end else begin
              phase = PH_DONE;
            end
          end
        end
        PH_FRAC: begin
          if (is_num(u)) begin
            if (!frac_over) begin
              v = int'(frac) * 10 + int'(u[3:0]);
              // The fraction saturates once it can no longer be a millisecond count.
              if (v >= 1000) begin
                frac_over = 1'b1;
                v = 1023;
              end
              frac = 10'(v);
            end
          end else begin
            phase = PH_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_unit(in_item_t it);
      out_item_t r;
      int y, mo, d, h, mi, s;
      if (it.has_unit) take_unit(it.code_unit);
      if (!it.end_of_line) return;
      r = '0;
      r.status = ST_NONE;
      if (phase != PH_SEARCH) begin
        y  = pair(0) * 100 + pair(2);
        mo = pair(4);
        d  = pair(6);
        h  = pair(8);
        mi = pair(10);
        s  = pair(12);
        r.year   = 14'(y);
        r.month  = 7'(mo);
        r.day    = 7'(d);
        r.hour   = 7'(h);
        r.minute = 7'(mi);
        r.second = 7'(s);
        if (y >= 1 && d >= 1 && d <= days_in_month(y, mo) && h < 24 && mi < 60 &&
            s < 60 && !frac_over) begin
          r.status = ST_VALID;
          r.millis = frac;
        end else begin
          r.status = ST_INVALID;
        end
      end
      awaited_outcomes.push_back(r);
      clear_line();
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_outcome(out_item_t got);
      out_item_t want;
      if (awaited_outcomes.size() == 0) begin
        $error("status: expected no result, got %0d", got.status);
        mismatches++;
        return;
      end
      want = awaited_outcomes.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("year", want.year, got.year);
      compare_field("month", want.month, got.month);
      compare_field("day", want.day, got.day);
      compare_field("hour", want.hour, got.hour);
      compare_field("minute", want.minute, got.minute);
      compare_field("second", want.second, got.second);
      compare_field("millis", want.millis, got.millis);
    endfunction

    function int awaited();
      return awaited_outcomes.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  iso_ts_in_if  units ();
  iso_ts_out_if results ();

  iso_timestamp_scanner dut (
    .clk     (clk),
    .rst     (rst),
    .units   (units),
    .results (results)
  );

  timestamp_outcome_board board = new();

  in_item_t line_buf [$];
  int       items_sent;
  int       sender_gap_odds;
  bit       quiet_tail;
  bit       hold_off_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("iso_timestamp_scanner_tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) board.check_outcome(results.data);
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    results.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_req) begin
        results.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(2) == 0) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(16, 1)) @(posedge clk);
      end else begin
        results.ready <= 1'b1;
        repeat ($urandom_range(64, 1)) @(posedge clk);
      end
    end
  end

  function automatic logic [15:0] any_unit();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'hFFFF));
      1: return 16'($urandom_range(16'h7E, 16'h20));
      2: return CH_ZERO + 16'($urandom_range(9));
      default: return ODD_UNITS[$urandom_range(13)];
    endcase
  endfunction

  function automatic void push_item(logic [15:0] u, logic has, logic eol);
    in_item_t it;
    it.code_unit   = u;
    it.has_unit    = has;
    it.end_of_line = eol;
    line_buf.push_back(it);
  endfunction

  // Empty items are sprinkled between units; they must change nothing.
  function automatic void add_unit(logic [15:0] u);
    if ($urandom_range(11) == 0) push_item(16'($urandom), 1'b0, 1'b0);
    push_item(u, 1'b1, 1'b0);
  endfunction

  function automatic void add_form(bit intact);
    int y, mo, d, h, mi, s, last;
    string txt;
    logic [15:0] f [WIN_LEN];
    case ($urandom_range(6))
      0: y = 0;
      1: y = 1;
      2: y = 9999;
      3: y = 400 * $urandom_range(24, 1);
      4: y = 100 * $urandom_range(99, 1);
      5: y = 4 * $urandom_range(2499, 1);
      default: y = $urandom_range(9999, 1);
    endcase
    mo   = $urandom_range(12, 1);
    last = timestamp_outcome_board::days_in_month(y, mo);
    d    = $urandom_range(1) ? last : $urandom_range(last, 1);
    h    = ($urandom_range(3) == 0) ? 23 : $urandom_range(23);
    mi   = ($urandom_range(3) == 0) ? 59 : $urandom_range(59);
    s    = ($urandom_range(3) == 0) ? 59 : $urandom_range(59);
    // Now and then push exactly one field out of its range.
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(4))
        0: mo = $urandom_range(1) ? 0 : 13 + $urandom_range(86);
        1: d = $urandom_range(1) ? 0 : last + 1 + $urandom_range(2);
        2: h = 24 + $urandom_range(75);
        3: mi = 60 + $urandom_range(39);
        default: s = 60 + $urandom_range(39);
      endcase
    end
    txt = $sformatf("%04d-%02d-%02d%s%02d:%02d:%02d", y, mo, d,
                    $urandom_range(1) ? "T" : " ", h, mi, s);
    for (int k = 0; k < WIN_LEN; k++) f[k] = {8'h00, txt[k]};
    if (!intact) f[$urandom_range(WIN_LEN - 1)] = any_unit();
    for (int k = 0; k < WIN_LEN; k++) add_unit(f[k]);
  endfunction

  function automatic void add_fraction();
    logic [15:0] mark;
    int pick, n;
    mark = $urandom_range(1) ? CH_DOT : CH_COMMA;
    pick = $urandom_range(9);
    if (pick < 3) return;
    add_unit(mark);
    if (pick < 8) begin
      n = (pick == 7) ? $urandom_range(6, 4) : $urandom_range(3, 1);
      for (int k = 0; k < n; k++) begin
        add_unit((pick == 6) ? CH_NINE : CH_ZERO + 16'($urandom_range(9)));
      end
    end else if (pick == 8) begin
      add_unit(any_unit());
    end
  endfunction

  function automatic void close_line();
    if (line_buf.size() == 0 || $urandom_range(3) == 0) begin
      push_item(any_unit(), 1'b0, 1'b1);
    end else begin
      line_buf[line_buf.size() - 1].end_of_line = 1'b1;
    end
  endfunction

  function automatic void build_random_line();
    int pick, n;
    string alphabet;
    alphabet = "00112233445566778899--::  TT.,";
    pick = $urandom_range(19);
    if (pick < 14) begin
      n = $urandom_range(6);
      repeat (n) add_unit(any_unit());
      add_form(pick < 11);
      add_fraction();
      n = $urandom_range(4);
      repeat (n) add_unit(any_unit());
      // A second form later in the line must not displace the first.
      if ($urandom_range(7) == 0) add_form(1'b1);
    end else if (pick < 17) begin
      n = $urandom_range(30);
      repeat (n) add_unit(any_unit());
    end else begin
      n = $urandom_range(40, 8);
      repeat (n) add_unit({8'h00, alphabet[$urandom_range(alphabet.len() - 1)]});
    end
    close_line();
  endfunction

  task automatic send_item(in_item_t it);
    if (!quiet_tail && sender_gap_odds != 0 && $urandom_range(sender_gap_odds) == 0) begin
      units.valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
    units.valid <= 1'b1;
    units.data  <= it;
    do @(posedge clk); while (!units.ready);
    board.note_unit(it);
    items_sent++;
    if (items_sent >= ITEM_TARGET - QUIET_TAIL_ITEMS) quiet_tail = 1'b1;
  endtask

  task automatic send_line();
    sender_gap_odds = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(4, 1)) - 1;
    foreach (line_buf[i]) send_item(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic drain();
    units.valid <= 1'b0;
    while (board.awaited() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    bit hold_done;
    bit pause_done;
    string extreme_text;
    hold_done    = 1'b0;
    pause_done   = 1'b0;
    extreme_text = "9999-12-31T23:59:59,";
    items_sent   = 0;
    quiet_tail   = 1'b0;
    hold_off_req = 1'b0;
    rst         <= 1'b1;
    units.valid <= 1'b0;
    units.data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // An empty line, then the largest fields with a separator that ends the line.
    push_item(16'hFFFF, 1'b0, 1'b1);
    for (int i = 0; i < extreme_text.len(); i++) begin
      push_item({8'h00, extreme_text[i]}, 1'b1, i == extreme_text.len() - 1);
      if (i == 10) push_item(16'h0000, 1'b0, 1'b0);
    end
    send_line();

    while (items_sent < ITEM_TARGET) begin
      if (!hold_done && items_sent >= 500) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      if (!pause_done && items_sent >= 900) begin
        drain();
        pause_done = 1'b1;
      end
      build_random_line();
      send_line();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.awaited() == 0) begin
      $display("iso_timestamp_scanner_tb: PASS");
    end else begin
      $display("iso_timestamp_scanner_tb: FAIL");
    end
    $finish;
  end

endmodule
